@@ hdl/response_frame_checker_assert.svh @@
// Assertion macros used by the port-level assertions of the response frame checker.
`ifndef RESPONSE_FRAME_CHECKER_ASSERT_SVH
`define RESPONSE_FRAME_CHECKER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define RFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/rfc_pkg.sv @@
// Types and constants of the response frame checker.
package rfc_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [2:0] t_status;
    typedef logic [2:0] t_cfg_idx;

    localparam t_kind KIND_BYTE   = 2'd0;
    localparam t_kind KIND_TICK   = 2'd1;
    localparam t_kind KIND_ARM    = 2'd2;
    localparam t_kind KIND_UNUSED = 2'd3;

    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_TIMEOUT      = 3'd1;
    localparam t_status ST_BAD_HEADER   = 3'd2;
    localparam t_status ST_BAD_LENGTH   = 3'd3;
    localparam t_status ST_BAD_CHECKSUM = 3'd4;
    localparam t_status ST_WRONG_FIELD  = 3'd5;

    localparam t_cfg_idx CFG_RESPONSE_BYTES   = 3'd0;
    localparam t_cfg_idx CFG_TIMEOUT_TICKS    = 3'd1;
    localparam t_cfg_idx CFG_EXPECTED_LENGTH  = 3'd2;
    localparam t_cfg_idx CFG_CHECK_LENGTH     = 3'd3;
    localparam t_cfg_idx CFG_EXPECTED_COMMAND = 3'd4;
    localparam t_cfg_idx CFG_CHECK_COMMAND    = 3'd5;

    localparam logic [7:0] HEAD0 = 8'hAA;
    localparam logic [7:0] HEAD1 = 8'h55;

    localparam logic [6:0]  RST_RESPONSE_BYTES   = 7'd9;
    localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd12000;
    localparam logic [7:0]  RST_EXPECTED_LENGTH  = 8'h06;
    localparam logic        RST_CHECK_LENGTH     = 1'b1;
    localparam logic [7:0]  RST_EXPECTED_COMMAND = 8'h21;
    localparam logic        RST_CHECK_COMMAND    = 1'b0;

    localparam logic [7:0]  MIN_COLLECT = 8'd4;
    localparam logic [15:0] TICK_MAX    = 16'hFFFF;

endpackage

@@ hdl/rfc_channels.sv @@
// Valid/ready channel interfaces of the response frame checker.
interface rfc_in_if;
    logic          valid;
    logic          ready;
    rfc_pkg::t_kind kind;
    logic [7:0]    rx_byte;
    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface rfc_out_if;
    logic             valid;
    logic             ready;
    rfc_pkg::t_status status;
    logic [7:0]       length_seen;
    logic [7:0]       command_seen;
    modport source (output valid, output status, output length_seen, output command_seen,
                    input ready);
    modport sink   (input valid, input status, input length_seen, input command_seen,
                    output ready);
endinterface

interface rfc_cfg_if;
    logic              valid;
    logic              ready;
    rfc_pkg::t_cfg_idx index;
    logic [15:0]       data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/response_frame_checker.sv @@
// Response frame checker: header, length, XOR checksum, field and timeout check of one frame.
// Usage:
// The i_in channel carries requests of three kinds: a received byte, a timer tick,
// or an arm request that starts the wait for a new frame. Bytes and ticks are ignored
// while the block is not armed. After the configured number of bytes, or after the
// configured number of ticks without a byte, one result request leaves on o_out with
// a status and the length and command bytes seen.
// The i_cfg channel writes the six configuration registers by index; it is always
// ready and should only be used while the block is idle.
// A request is registered on acceptance and processed once the output register is free;
// the result is registered in the output register. One request is accepted per cycle
// unless the receiver stalls; the throughput is set by the single processing stage.
// When the receiver stalls, the result is held in the output register and one more
// request is taken into the input register; acceptance then stops until the result
// is taken.
// Reset (synchronous, active low) disarms the block, empties both registers and
// restores the configuration defaults.
module response_frame_checker #(
    parameter int MAX_FRAME = 64
) (
    input logic      i_clk,
    input logic      i_rst_n,
    rfc_cfg_if.sink  i_cfg,
    rfc_in_if.sink   i_in,
    rfc_out_if.source o_out
);
    import rfc_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAME + 1);

    logic [6:0]  r_response_bytes;
    logic [15:0] r_timeout_ticks;
    logic [7:0]  r_expected_length;
    logic        r_check_length;
    logic [7:0]  r_expected_command;
    logic        r_check_command;

    logic        r_in_valid;
    t_kind       r_kind;
    logic [7:0]  r_byte;

    logic             r_armed, n_armed;
    logic [IDX_W-1:0] r_index, n_index;
    logic             r_header_good, n_header_good;
    logic [7:0]       r_length, n_length;
    logic [7:0]       r_command, n_command;
    logic [7:0]       r_xor, n_xor;
    logic [15:0]      r_idle, n_idle;

    logic        r_out_valid, n_out_valid;
    t_status     r_status, n_status;
    logic [7:0]  r_length_seen, n_length_seen;
    logic [7:0]  r_command_seen, n_command_seen;

    logic       advance;
    logic       proc;
    logic       emit;
    t_status    status;
    logic [7:0] collect_n;
    logic [8:0] index_ext;

    assign advance     = !r_out_valid || o_out.ready;
    assign proc        = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if ({1'b0, r_response_bytes} < MIN_COLLECT) begin
            collect_n = MIN_COLLECT;
        end else if ({1'b0, r_response_bytes} > 8'(MAX_FRAME)) begin
            collect_n = 8'(MAX_FRAME);
        end else begin
            collect_n = {1'b0, r_response_bytes};
        end
    end

    always_comb begin
        n_armed       = r_armed;
        n_index       = r_index;
        n_header_good = r_header_good;
        n_length      = r_length;
        n_command     = r_command;
        n_xor         = r_xor;
        n_idle        = r_idle;
        emit          = 1'b0;
        status        = ST_OK;
        index_ext     = 9'(r_index) + 9'd1;
        if (proc) begin
            unique case (r_kind)
                KIND_ARM: begin
                    n_armed       = 1'b1;
                    n_index       = '0;
                    n_header_good = 1'b1;
                    n_length      = '0;
                    n_command     = '0;
                    n_xor         = '0;
                    n_idle        = '0;
                end
                KIND_TICK: begin
                    if (r_armed) begin
                        n_idle = (r_idle != TICK_MAX) ? r_idle + 16'd1 : r_idle;
                        if (n_idle >= r_timeout_ticks) begin
                            emit    = 1'b1;
                            status  = ST_TIMEOUT;
                            n_armed = 1'b0;
                        end
                    end
                end
                KIND_BYTE: begin
                    if (r_armed) begin
                        n_idle = '0;
                        if (r_index == IDX_W'(0)) begin
                            if (r_byte != HEAD0) n_header_good = 1'b0;
                        end else if (r_index == IDX_W'(1)) begin
                            if (r_byte != HEAD1) n_header_good = 1'b0;
                        end else if (r_index == IDX_W'(2)) begin
                            n_length = r_byte;
                            n_xor    = r_byte;
                        end else begin
                            if (r_index == IDX_W'(3)) n_command = r_byte;
                            if (9'(r_index) <= 9'(r_length) + 9'd2) n_xor = r_xor ^ r_byte;
                        end
                        n_index = IDX_W'(index_ext);
                        if (index_ext >= 9'(collect_n)) begin
                            emit    = 1'b1;
                            n_armed = 1'b0;
                            priority if (!n_header_good) begin
                                status = ST_BAD_HEADER;
                            end else if (9'(n_length) + 9'd3 > 9'(collect_n)) begin
                                status = ST_BAD_LENGTH;
                            end else if (n_xor != 8'd0) begin
                                status = ST_BAD_CHECKSUM;
                            end else if (r_check_length && n_length != r_expected_length) begin
                                status = ST_WRONG_FIELD;
                            end else if (r_check_command
                                         && n_command != r_expected_command) begin
                                status = ST_WRONG_FIELD;
                            end else begin
                                status = ST_OK;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_status       = r_status;
        n_length_seen  = r_length_seen;
        n_command_seen = r_command_seen;
        if (emit) begin
            n_out_valid    = 1'b1;
            n_status       = status;
            n_length_seen  = n_length;
            n_command_seen = n_command;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_bytes   <= RST_RESPONSE_BYTES;
            r_timeout_ticks    <= RST_TIMEOUT_TICKS;
            r_expected_length  <= RST_EXPECTED_LENGTH;
            r_check_length     <= RST_CHECK_LENGTH;
            r_expected_command <= RST_EXPECTED_COMMAND;
            r_check_command    <= RST_CHECK_COMMAND;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_RESPONSE_BYTES:   r_response_bytes   <= i_cfg.data[6:0];
                CFG_TIMEOUT_TICKS:    r_timeout_ticks    <= i_cfg.data;
                CFG_EXPECTED_LENGTH:  r_expected_length  <= i_cfg.data[7:0];
                CFG_CHECK_LENGTH:     r_check_length     <= i_cfg.data[0];
                CFG_EXPECTED_COMMAND: r_expected_command <= i_cfg.data[7:0];
                CFG_CHECK_COMMAND:    r_check_command    <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_armed       <= 1'b0;
            r_index       <= '0;
            r_header_good <= 1'b1;
            r_length      <= '0;
            r_command     <= '0;
            r_xor         <= '0;
            r_idle        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            r_armed       <= n_armed;
            r_index       <= n_index;
            r_header_good <= n_header_good;
            r_length      <= n_length;
            r_command     <= n_command;
            r_xor         <= n_xor;
            r_idle        <= n_idle;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.rx_byte;
        end
        r_status       <= n_status;
        r_length_seen  <= n_length_seen;
        r_command_seen <= n_command_seen;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.length_seen  = r_length_seen;
    assign o_out.command_seen = r_command_seen;

endmodule

@@ hdl/rfc_checker.sv @@
// Port-level assertions of the response frame checker and their binding.
`include "response_frame_checker_assert.svh"

module rfc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input rfc_pkg::t_status i_status,
    input logic [7:0]       i_length_seen,
    input logic [7:0]       i_command_seen
);
    import rfc_pkg::*;

    // No result may be pending in the cycle after reset.
    `RFC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result pending after reset")

    // Every result carries one of the defined status codes.
    `RFC_ASSERT(a_status_code,
                i_out_valid |-> (i_status <= ST_WRONG_FIELD),
                "undefined status")

    // A stalled result keeps its contents until it is taken.
    `RFC_ASSERT(a_stall_hold,
                i_out_valid && !i_out_ready |=>
                    i_out_valid && $stable({i_status, i_length_seen, i_command_seen}),
                "stalled result changed")

endmodule

bind response_frame_checker rfc_checker u_rfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_length_seen  (o_out.length_seen),
    .i_command_seen (o_out.command_seen)
);

@@ tb/frame_verdict_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts each response frame verdict and compares it with the block's results.
module frame_verdict_checker #(
    parameter int MAX_FRAME = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rfc_cfg_if   i_cfg,
    rfc_in_if    i_req,
    rfc_out_if   i_res,
    output int   o_failures,
    output int   o_pending
);
    import rfc_pkg::*;

    typedef struct packed {
        t_status    status;
        logic [7:0] length_seen;
        logic [7:0] command_seen;
    } t_verdict;

    logic [6:0]  want_bytes;
    logic [15:0] tick_limit;
    logic [7:0]  want_len;
    logic        len_chk;
    logic [7:0]  want_cmd;
    logic        cmd_chk;

    logic        waiting;
    logic [6:0]  pos;
    logic        hdr_ok;
    logic [7:0]  len_field;
    logic [7:0]  cmd_field;
    logic [7:0]  running_xor;
    logic [15:0] quiet_ticks;

    t_verdict pending_verdicts[$];
    int fail_cnt = 0;

    function automatic void clear_frame();
        pos = '0;
        hdr_ok = 1'b1;
        len_field = '0;
        cmd_field = '0;
        running_xor = '0;
        quiet_ticks = '0;
    endfunction

    function automatic bit take_request(input t_kind kind, input logic [7:0] rx,
                                        output t_verdict v);
        int n;
        t_status st;
        v = '0;
        if (kind == KIND_ARM) begin
            waiting = 1'b1;
            clear_frame();
            return 1'b0;
        end
        if (!waiting || kind == KIND_UNUSED) return 1'b0;
        if (kind == KIND_TICK) begin
            if (quiet_ticks != TICK_MAX) quiet_ticks++;
            if (quiet_ticks < tick_limit) return 1'b0;
            v = '{ST_TIMEOUT, len_field, cmd_field};
            waiting = 1'b0;
            return 1'b1;
        end
        quiet_ticks = '0;
        if (pos == 0) begin
            if (rx != HEAD0) hdr_ok = 1'b0;
        end else if (pos == 1) begin
            if (rx != HEAD1) hdr_ok = 1'b0;
        end else if (pos == 2) begin
            len_field = rx;
            running_xor = rx;
        end else begin
            if (pos == 3) cmd_field = rx;
            if (int'(pos) <= int'(len_field) + 2) running_xor ^= rx;
        end
        pos++;
        n = int'(want_bytes);
        if (n < int'(MIN_COLLECT)) n = int'(MIN_COLLECT);
        if (n > MAX_FRAME) n = MAX_FRAME;
        if (int'(pos) < n) return 1'b0;
        if (!hdr_ok) st = ST_BAD_HEADER;
        else if (int'(len_field) + 3 > n) st = ST_BAD_LENGTH;
        else if (running_xor != 0) st = ST_BAD_CHECKSUM;
        else if ((len_chk && len_field != want_len) || (cmd_chk && cmd_field != want_cmd))
            st = ST_WRONG_FIELD;
        else st = ST_OK;
        v = '{st, len_field, cmd_field};
        waiting = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            want_bytes = RST_RESPONSE_BYTES;
            tick_limit = RST_TIMEOUT_TICKS;
            want_len = RST_EXPECTED_LENGTH;
            len_chk = RST_CHECK_LENGTH;
            want_cmd = RST_EXPECTED_COMMAND;
            cmd_chk = RST_CHECK_COMMAND;
            waiting = 1'b0;
            clear_frame();
            pending_verdicts.delete();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                got = '{i_res.status, i_res.length_seen, i_res.command_seen};
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result: status %0d, length_seen %0d, command_seen %0d",
                           got.status, got.length_seen, got.command_seen);
                    fail_cnt++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fail_cnt++;
                    end
                    if (got.length_seen !== want.length_seen) begin
                        $error("length_seen mismatch: expected %0d, actual %0d",
                               want.length_seen, got.length_seen);
                        fail_cnt++;
                    end
                    if (got.command_seen !== want.command_seen) begin
                        $error("command_seen mismatch: expected %0d, actual %0d",
                               want.command_seen, got.command_seen);
                        fail_cnt++;
                    end
                end
            end
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) begin
                case (i_cfg.index)
                    CFG_RESPONSE_BYTES:   want_bytes = i_cfg.data[6:0];
                    CFG_TIMEOUT_TICKS:    tick_limit = i_cfg.data;
                    CFG_EXPECTED_LENGTH:  want_len = i_cfg.data[7:0];
                    CFG_CHECK_LENGTH:     len_chk = i_cfg.data[0];
                    CFG_EXPECTED_COMMAND: want_cmd = i_cfg.data[7:0];
                    CFG_CHECK_COMMAND:    cmd_chk = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                if (take_request(i_req.kind, i_req.rx_byte, want))
                    pending_verdicts.push_back(want);
            end
        end
        o_failures <= fail_cnt;
        o_pending <= pending_verdicts.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: drives frame requests and register writes into the response frame checker.
module tb;
    import rfc_pkg::*;

    localparam int MAX_FRAME = 64;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 600;

    typedef logic [7:0] t_byte_q[$];

    logic i_clk;
    logic i_rst_n;
    int   failures;
    int   pending;
    int   cycles = 0;
    int   sent = 0;

    bit sender_idles = 1'b1;
    bit no_gaps = 1'b0;
    bit receiver_stalls = 1'b1;
    bit hold_results = 1'b0;

    logic [6:0]  cur_bytes = RST_RESPONSE_BYTES;
    logic [15:0] cur_timeout = RST_TIMEOUT_TICKS;
    logic [7:0]  cur_exp_len = RST_EXPECTED_LENGTH;
    logic        cur_chk_len = RST_CHECK_LENGTH;
    logic [7:0]  cur_exp_cmd = RST_EXPECTED_COMMAND;
    logic        cur_chk_cmd = RST_CHECK_COMMAND;

    rfc_cfg_if cfg_ch ();
    rfc_in_if  req_ch ();
    rfc_out_if res_ch ();

    response_frame_checker #(.MAX_FRAME(MAX_FRAME)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    frame_verdict_checker #(.MAX_FRAME(MAX_FRAME)) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_ch),
        .i_req      (req_ch),
        .i_res      (res_ch),
        .o_failures (failures),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : receiver
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            if (hold_results) begin
                stall = HOLD_CYCLES;
                hold_results = 1'b0;
            end else begin
                if ($urandom_range(0, 31) == 0) receiver_stalls = !receiver_stalls;
                stall = receiver_stalls ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    task automatic push(input t_kind kind, input logic [7:0] rx);
        int gap;
        if ($urandom_range(0, 63) == 0) sender_idles = !sender_idles;
        gap = (sender_idles && !no_gaps) ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.rx_byte <= rx;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sent++;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_RESPONSE_BYTES:   cur_bytes = val[6:0];
            CFG_TIMEOUT_TICKS:    cur_timeout = val;
            CFG_EXPECTED_LENGTH:  cur_exp_len = val[7:0];
            CFG_CHECK_LENGTH:     cur_chk_len = val[0];
            CFG_EXPECTED_COMMAND: cur_exp_cmd = val[7:0];
            CFG_CHECK_COMMAND:    cur_chk_cmd = val[0];
            default: ;
        endcase
    endtask

    task automatic reconfigure(input int rb, input int to, input int el, input int cl,
                               input int ec, input int cc);
        settle();
        write_reg(CFG_RESPONSE_BYTES, 16'(rb));
        write_reg(CFG_TIMEOUT_TICKS, 16'(to));
        write_reg(CFG_EXPECTED_LENGTH, 16'(el));
        write_reg(CFG_CHECK_LENGTH, 16'(cl));
        write_reg(CFG_EXPECTED_COMMAND, 16'(ec));
        write_reg(CFG_CHECK_COMMAND, 16'(cc));
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic arm_and_send(input t_byte_q seq);
        push(KIND_ARM, 8'($urandom));
        foreach (seq[i]) push(KIND_BYTE, seq[i]);
    endtask

    task automatic send_frame();
        logic [7:0] fb[MAX_FRAME];
        logic [7:0] sum;
        int n, len, fate, cut, ticks, i;
        n = int'(cur_bytes);
        if (n < int'(MIN_COLLECT)) n = int'(MIN_COLLECT);
        if (n > MAX_FRAME) n = MAX_FRAME;
        fate = $urandom_range(0, 99);
        cut = $urandom_range(0, n - 1);
        if (cur_chk_len && int'(cur_exp_len) + 3 <= n && $urandom_range(0, 1) == 1)
            len = int'(cur_exp_len);
        else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(0, 255);
        else
            len = $urandom_range(0, n - 3);
        fb[0] = HEAD0;
        fb[1] = HEAD1;
        fb[2] = len[7:0];
        for (i = 3; i < n; i++) fb[i] = 8'($urandom);
        if (cur_chk_cmd && $urandom_range(0, 2) != 0) fb[3] = cur_exp_cmd;
        if (len > 0 && len + 3 <= n) begin
            sum = '0;
            for (i = 2; i < len + 2; i++) sum ^= fb[i];
            fb[len + 2] = sum;
        end
        if (fate < 6)
            fb[$urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
        else if (fate < 14)
            fb[$urandom_range(2, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
        // An early arm followed by a partial frame that the real arm must discard.
        if (fate >= 14 && fate < 18) begin
            push(KIND_ARM, 8'($urandom));
            for (i = 0; i < cut; i++) push(KIND_BYTE, fb[i]);
        end
        push(KIND_ARM, 8'($urandom));
        for (i = 0; i < n; i++) begin
            if (fate >= 18 && fate < 26 && i == cut && cur_timeout <= 64) begin
                repeat (cur_timeout == 0 ? 1 : int'(cur_timeout)) push(KIND_TICK, 8'($urandom));
                break;
            end
            if (cur_timeout > 1 && $urandom_range(0, 7) == 0) begin
                ticks = $urandom_range(1, cur_timeout - 1 < 5 ? int'(cur_timeout) - 1 : 5);
                repeat (ticks) push(KIND_TICK, 8'($urandom));
            end
            if ($urandom_range(0, 15) == 0) push(KIND_UNUSED, 8'($urandom));
            push(KIND_BYTE, fb[i]);
        end
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
                0: push(KIND_BYTE, 8'($urandom));
                1: push(KIND_TICK, 8'($urandom));
                default: push(KIND_UNUSED, 8'($urandom));
            endcase
        end
    endtask

    initial begin : stimulus
        int base, rb, to, el, nframes;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_BYTE;
        req_ch.rx_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_RESPONSE_BYTES;
        cfg_ch.data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests while idle are dropped; then one good frame under the reset settings.
        push(KIND_BYTE, HEAD0);
        push(KIND_TICK, 8'hFF);
        push(KIND_UNUSED, 8'hFF);
        arm_and_send('{HEAD0, HEAD1, 8'h06, 8'h21, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h59});

        reconfigure(0, 0, 0, 0, 8'h21, 1);
        arm_and_send('{HEAD0, HEAD1, 8'h00, 8'h21});
        arm_and_send('{HEAD0, HEAD1, 8'h01, 8'h01});
        arm_and_send('{HEAD0, HEAD1, 8'h01, 8'hFF});
        arm_and_send('{HEAD0, HEAD1, 8'h02, 8'h00});
        arm_and_send('{HEAD1, HEAD1, 8'h00, 8'h21});
        push(KIND_ARM, 8'h00);
        push(KIND_TICK, 8'h00);
        arm_and_send('{HEAD0});
        arm_and_send('{HEAD0, HEAD1, 8'h00, 8'h21});

        reconfigure(127, 65535, 255, 1, 255, 1);
        repeat (3) send_frame();

        reconfigure(64, 1, 0, 1, 0, 1);
        repeat (3) send_frame();

        // The receiver stalls while requests keep coming so the block backs up.
        reconfigure(0, 20, 0, 0, 0, 0);
        hold_results = 1'b1;
        no_gaps = 1'b1;
        repeat (30) send_frame();
        no_gaps = 1'b0;

        base = sent;
        while (sent - base < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       rb = $urandom_range(65, 127);
                1, 2:    rb = $urandom_range(13, 64);
                default: rb = $urandom_range(0, 12);
            endcase
            to = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 65535) : $urandom_range(0, 20);
            el = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9);
            reconfigure(rb, to, el, $urandom_range(0, 1), $urandom_range(0, 255),
                        $urandom_range(0, 1));
            nframes = (rb > 16) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            repeat (nframes) send_frame();
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
